/* rtl/core/pmts_pkg.sv */
`timescale 1ns / 1ps

package pmts_pkg;

  // Shared operand width of the serial multiplier and angle width of the CORDIC
  localparam int MUL_W        = 36;
  localparam int ANG_W        = 35;
  localparam int ATAN_ENTRIES = 30;

  localparam logic [63:0] PI_Q60          = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI30            = (PI_Q60 + 64'd536870912) >> 30;
  localparam logic [63:0] HALF_PI30       = (PI_Q60 + 64'd1073741824) >> 31;
  localparam logic [63:0] DEG2RAD_Q32     = 64'd74961321;
  localparam logic [63:0] RAD2DEG_Q24     = 64'd961263669;
  localparam logic [63:0] INV_SQRT2_Q30   = 64'd759250125;
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;
  localparam logic [9:0]  DEG_FULL        = 10'd360;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    KIND_NONE   = 4'd0,
    KIND_CIRC   = 4'd1,
    KIND_SINE   = 4'd2,
    KIND_RECT   = 4'd3,
    KIND_CUBIC  = 4'd4,
    KIND_DRIFT  = 4'd5,
    KIND_LOOP   = 4'd6,
    KIND_RANDOM = 4'd7,
    KIND_SAW    = 4'd8,
    KIND_PULSE  = 4'd9
  } term_kind_e;

  // pi rounded to fb fraction bits
  function automatic logic [63:0] pi_at(input int unsigned fb);
    return (PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
  endfunction

endpackage

/* rtl/core/pmts_mul.sv */
`timescale 1ns / 1ps

// Bit-serial signed multiplier: one multiplier bit per cycle on magnitudes.
module pmts_mul #(
  parameter int WA = 36,
  parameter int WB = 36
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic                    done_o,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int CW = $clog2(WB + 1);

  logic [WA-1:0]    mcand_q, mcand_d;
  logic [WA+WB-1:0] acc_q, acc_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             neg_q, neg_d;
  logic [WA:0]      upper;

  always_comb begin
    mcand_d = mcand_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    neg_d   = neg_q;
    upper   = {1'b0, acc_q[WA+WB-1:WB]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    if (start_i) begin
      mcand_d = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
      acc_d   = {{WA{1'b0}}, (b_i[WB-1] ? WB'(-b_i) : WB'(b_i))};
      cnt_d   = CW'(WB);
      run_d   = 1'b1;
      neg_d   = a_i[WA-1] ^ b_i[WB-1];
    end else if (run_q) begin
      if (cnt_q != '0) begin
        acc_d = {upper, acc_q[WB-1:1]};
        cnt_d = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign done_o = run_q && (cnt_q == '0);
  assign p_o    = neg_q ? (WA+WB)'(-acc_q) : acc_q;

endmodule

/* rtl/core/pmts_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pmts_div #(
  parameter int WN = 64,
  parameter int WD = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [WN-1:0] n_i,
  input  logic [WD-1:0] d_i,
  output logic          done_o,
  output logic [WN-1:0] q_o,
  output logic [WD-1:0] r_o
);

  localparam int CW = $clog2(WN + 1);

  logic [WN-1:0] quo_q, quo_d;
  logic [WD-1:0] rem_q, rem_d;
  logic [WD-1:0] dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic [WD:0]   trial, sub;
  logic          ge;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    run_d = run_q;
    trial = {rem_q, quo_q[WN-1]};
    sub   = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
    if (start_i) begin
      quo_d = n_i;
      rem_d = '0;
      dsr_d = d_i;
      cnt_d = CW'(WN);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? sub[WD-1:0] : trial[WD-1:0];
        quo_d = {quo_q[WN-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = run_q && (cnt_q == '0);
  assign q_o    = quo_q;
  assign r_o    = rem_q;

endmodule

/* rtl/core/pmts_cordic.sv */
`timescale 1ns / 1ps

// Iterative CORDIC rotator, one micro-rotation per cycle. Angle in Q5.30,
// range [0, 2*pi); folded to [-pi/2, pi/2] before rotating.
module pmts_cordic #(
  parameter int STEPS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [pmts_pkg::ANG_W-1:0] z_i,
  input  logic                             neg_i,
  output logic                             done_o,
  output logic signed [pmts_pkg::ANG_W-1:0] sin_o,
  output logic signed [pmts_pkg::ANG_W-1:0] cos_o
);

  import pmts_pkg::*;

  localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
  localparam int IW    = $clog2(NSTEP + 1);
  localparam int AIW   = $clog2(ATAN_ENTRIES);

  localparam logic signed [ANG_W-1:0] PI_A     = ANG_W'(PI30);
  localparam logic signed [ANG_W-1:0] TWO_PI_A = ANG_W'(PI30 << 1);
  localparam logic signed [ANG_W-1:0] HALF_A   = ANG_W'(HALF_PI30);
  localparam logic signed [ANG_W-1:0] GAIN_A   = ANG_W'(CORDIC_GAIN_Q30);

  logic signed [ANG_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [ANG_W-1:0] z_f, dx, dy, at;
  logic [IW-1:0]           i_q, i_d;
  logic [AIW-1:0]          aidx;
  logic                    run_q, run_d;
  logic                    flip_q, flip_d, neg_q, neg_d, flip_f;

  assign aidx = AIW'(i_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    run_d  = run_q;
    flip_d = flip_q;
    neg_d  = neg_q;
    // quadrant fold
    z_f    = z_i;
    flip_f = 1'b0;
    if (z_f > PI_A) z_f = z_f - TWO_PI_A;
    if (z_f > HALF_A) begin
      z_f    = z_f - PI_A;
      flip_f = 1'b1;
    end else if (z_f < -HALF_A) begin
      z_f    = z_f + PI_A;
      flip_f = 1'b1;
    end
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = ANG_W'(ATAN_Q30[aidx]);
    if (start_i) begin
      x_d    = GAIN_A;
      y_d    = '0;
      z_d    = z_f;
      i_d    = '0;
      run_d  = 1'b1;
      flip_d = flip_f;
      neg_d  = neg_i;
    end else if (run_q) begin
      if (i_q != IW'(NSTEP)) begin
        if (!z_q[ANG_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        i_d = i_q + 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      run_q <= 1'b0;
    end else begin
      i_q   <= i_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    neg_q  <= neg_d;
  end

  assign done_o = run_q && (i_q == IW'(NSTEP));
  assign sin_o  = (flip_q ^ neg_q) ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

/* rtl/core/periodic_motion_term_summer_top.sv */
`timescale 1ns / 1ps

// Periodic motion term summer: builds one axis position from a list of terms.
// Input channel s_axis_*: one transaction per term. The term with first_term
//   set loads base_value into the running sum before its own term is added.
//   Terms add shaped sine/cosine or sawtooth values; tlast marks the last term.
// Output channel m_axis_*: one transaction per term with tlast set, carrying
//   the saturated sum and a sticky saturation flag.
// Sequencing: one term at a time. A term runs through a bit-serial
//   multiplier, a bit-serial divider for the angle reduction and an
//   iterative CORDIC. The base path is four products, one reduction and
//   one CORDIC. Cubic terms add a product. Loop terms add a reduction, a
//   CORDIC and a product; sawtooth on the Y axis adds a product and a
//   division by 360. tready is high only between terms.
// Reset: sum and flag clear, no transaction pending on the output.
// Stall: the result sits in an output register; the next term is accepted
//   and computed meanwhile, and only a further tlast term waits for it.
module periodic_motion_term_summer_top #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] base_value, [37:32] term_index, [69:38] amplitude, [101:70] speed,
  // [133:102] phase_deg, [165:134] time_angle, [167:166] zero
  input  logic [167:0] s_axis_tdata_i,
  // [1:0] axis, [2] first_term, [6:3] term_kind
  input  logic [6:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,   // last_term
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o,   // [31:0] position
  output logic         m_axis_tuser_o    // [0] saturated
);

  import pmts_pkg::*;

  localparam int DIV_W  = 2 * FRAC_BITS + 4;
  localparam int RED_SH = 2 * FRAC_BITS - 30;
  localparam int SH_R   = (RED_SH > 0) ? RED_SH : 0;
  localparam int SH_L   = (RED_SH < 0) ? -RED_SH : 0;
  localparam int SH_P   = 30 - FRAC_BITS;

  localparam logic [DIV_W-1:0] D_THETA = DIV_W'(pi_at(2 * FRAC_BITS) << 1);
  localparam logic [DIV_W-1:0] D_DIFF  = DIV_W'(pi_at(FRAC_BITS) << 1);
  localparam logic [DIV_W-1:0] D_DEG   = DIV_W'(DEG_FULL);
  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_DRAD   = 12'b0000_0000_0010,  // phase to radians
    ST_PROD   = 12'b0000_0000_0100,  // theta = speed * diff
    ST_RED    = 12'b0000_0000_1000,  // theta mod 2pi
    ST_COR    = 12'b0000_0001_0000,
    ST_DEG    = 12'b0000_0010_0000,  // reduced theta in degrees
    ST_RED2   = 12'b0000_0100_0000,  // loop: diff mod 2pi
    ST_COR2   = 12'b0000_1000_0000,
    ST_M4     = 12'b0001_0000_0000,  // amplitude * trig
    ST_M5     = 12'b0010_0000_0000,  // second product (cubic, loop)
    ST_SAWMUL = 12'b0100_0000_0000,
    ST_ACC    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // term context
  logic [1:0]               axis_q, axis_d;
  logic [3:0]               kind_q, kind_d;
  logic                     odd_q, odd_d, last_q, last_d;
  logic signed [31:0]       amp_q, amp_d, speed_q, speed_d, ang_q, ang_d;
  logic signed [31:0]       diff_q, diff_d;
  logic signed [63:0]       prod_q, prod_d;
  logic                     neg_q, neg_d, sawneg_q, sawneg_d;
  logic signed [ANG_W-1:0]  r30_q, r30_d, st_q, st_d, ct_q, ct_d, sp_q, sp_d, cp_q, cp_d;
  logic signed [9:0]        gang_q, gang_d;
  logic signed [65:0]       term_q, term_d;

  // accumulator and output register
  logic signed [31:0]       sum_q, sum_d, pos_q, pos_d;
  logic                     sat_q, sat_d, osat_q, osat_d, ovalid_q, ovalid_d;

  // unit launch registers
  logic                     mul_start_q, mul_start_d, div_start_q, div_start_d;
  logic                     cor_start_q, cor_start_d, cor_neg_q, cor_neg_d;
  logic signed [MUL_W-1:0]  mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [63:0]              div_n_q, div_n_d;
  logic [DIV_W-1:0]         div_d_q, div_d_d;
  logic signed [ANG_W-1:0]  cor_z_q, cor_z_d;

  logic                     mul_done, div_done, cor_done;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [63:0]              div_q;
  logic [DIV_W-1:0]         div_r;
  logic signed [ANG_W-1:0]  cor_s, cor_c;

  // datapath helpers
  logic signed [2*MUL_W-1:0] rnd32, rnd30;
  logic signed [39:0]       drad;
  logic signed [40:0]       diff_w;
  logic signed [31:0]       diff_sat;
  logic signed [41:0]       t_rnd;
  logic [63:0]              rem_w, abs_p;
  logic signed [ANG_W-1:0]  r30_red, r30_diff, m4_trig;
  logic [9:0]               gdeg_raw, gdeg;
  logic signed [63:0]       drift_rnd;
  logic                     use_cos, cubic_yz, accept, out_free;
  logic [1:0]               region;
  logic signed [65:0]       amp_w, cubic_term;
  logic signed [66:0]       sum_w;

  pmts_mul #(.WA(MUL_W), .WB(MUL_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pmts_div #(.WN(64), .WD(DIV_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .n_i     (div_n_q),
    .d_i     (div_d_q),
    .done_o  (div_done),
    .q_o     (div_q),
    .r_o     (div_r)
  );

  pmts_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start_q),
    .z_i     (cor_z_q),
    .neg_i   (cor_neg_q),
    .done_o  (cor_done),
    .sin_o   (cor_s),
    .cos_o   (cor_c)
  );

  // Phase to radians: round(ph * deg2rad / 2^32), then saturated difference.
  assign rnd32  = mul_p + (2*MUL_W)'(64'sd2147483648);
  assign drad   = 40'(rnd32 >>> 32);
  assign diff_w = 41'(ang_q) - 41'(drad);
  assign diff_sat = (diff_w[40:31] != {10{diff_w[40]}}) ?
                    (diff_w[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff_w[31:0];

  // Products with a Q2.30 factor round half up at bit 30
  assign rnd30 = mul_p + (2*MUL_W)'(64'sd536870912);
  assign t_rnd = 42'(rnd30 >>> 30);

  assign abs_p    = mul_p[2*MUL_W-1] ? 64'(-mul_p) : 64'(mul_p);

  // Remainder to Q5.30
  assign rem_w    = 64'(div_r);
  assign r30_red  = ANG_W'((rem_w >> SH_R) << SH_L);
  assign r30_diff = ANG_W'(rem_w << SH_P);

  // Degrees of the reduced angle, with C-style sign
  assign gdeg_raw = mul_p[63:54];
  assign gdeg     = (gdeg_raw >= DEG_FULL) ? gdeg_raw - DEG_FULL : gdeg_raw;

  assign drift_rnd = (prod_q + HALF_LSB) >>> FRAC_BITS;
  assign use_cos   = ((axis_q == AXIS_X) && !odd_q) || ((axis_q == AXIS_Y) && odd_q);
  assign cubic_yz  = (axis_q == AXIS_Y) || ((axis_q == AXIS_Z) && !odd_q);
  assign amp_w     = 66'(amp_q);

  always_comb begin
    case (kind_q)
      KIND_SINE, KIND_DRIFT: m4_trig = st_q;
      KIND_RECT: begin
        m4_trig = use_cos ? ct_q : st_q;
        if (m4_trig[ANG_W-1]) m4_trig = -m4_trig;
      end
      default: m4_trig = use_cos ? ct_q : st_q;
    endcase
  end

  // Cubic regions: 0 below 45 or from 315, 1 to 135, 2 to 225, 3 to 315
  always_comb begin
    if ((gang_q < 10'sd45) || (gang_q >= 10'sd315)) region = 2'd0;
    else if (gang_q < 10'sd135)                     region = 2'd1;
    else if (gang_q < 10'sd225)                     region = 2'd2;
    else                                            region = 2'd3;
  end

  always_comb begin
    if (cubic_yz) begin
      if (region == 2'd1)      cubic_term = amp_w;
      else if (region == 2'd3) cubic_term = -amp_w;
      else                     cubic_term = 66'(t_rnd);
    end else if ((region == 2'd1) || (region == 2'd3)) begin
      cubic_term = 66'(t_rnd);
    end else if ((axis_q == AXIS_X) && !odd_q) begin
      cubic_term = (region == 2'd0) ? amp_w : -amp_w;
    end else begin
      cubic_term = (region == 2'd0) ? -amp_w : amp_w;
    end
  end

  assign accept   = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign sum_w    = 67'(sum_q) + 67'(term_q);

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    kind_d      = kind_q;
    odd_d       = odd_q;
    last_d      = last_q;
    amp_d       = amp_q;
    speed_d     = speed_q;
    ang_d       = ang_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    sawneg_d    = sawneg_q;
    r30_d       = r30_q;
    st_d        = st_q;
    ct_d        = ct_q;
    sp_d        = sp_q;
    cp_d        = cp_q;
    gang_d      = gang_q;
    term_d      = term_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    pos_d       = pos_q;
    osat_d      = osat_q;
    ovalid_d    = ovalid_q && !m_axis_tready_i;
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    cor_start_d = 1'b0;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    div_n_d     = div_n_q;
    div_d_d     = div_d_q;
    cor_z_d     = cor_z_q;
    cor_neg_d   = cor_neg_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          axis_d  = s_axis_tuser_i[1:0];
          kind_d  = s_axis_tuser_i[6:3];
          odd_d   = s_axis_tdata_i[32];
          last_d  = s_axis_tlast_i;
          amp_d   = s_axis_tdata_i[69:38];
          speed_d = s_axis_tdata_i[101:70];
          ang_d   = s_axis_tdata_i[165:134];
          if (s_axis_tuser_i[2]) begin
            sum_d = s_axis_tdata_i[31:0];
            sat_d = 1'b0;
          end
          mul_a_d     = MUL_W'($signed(s_axis_tdata_i[133:102]));
          mul_b_d     = MUL_W'(DEG2RAD_Q32);
          mul_start_d = 1'b1;
          state_d     = ST_DRAD;
        end
      end
      ST_DRAD: begin
        if (mul_done) begin
          diff_d      = diff_sat;
          mul_a_d     = MUL_W'(speed_q);
          mul_b_d     = MUL_W'(diff_sat);
          mul_start_d = 1'b1;
          state_d     = ST_PROD;
        end
      end
      ST_PROD: begin
        if (mul_done) begin
          prod_d      = 64'(mul_p);
          neg_d       = mul_p[2*MUL_W-1];
          div_n_d     = mul_p[2*MUL_W-1] ? 64'(-mul_p) : 64'(mul_p);
          div_d_d     = D_THETA;
          div_start_d = 1'b1;
          state_d     = ST_RED;
        end
      end
      ST_RED: begin
        if (div_done) begin
          r30_d       = r30_red;
          cor_z_d     = r30_red;
          cor_neg_d   = neg_q;
          cor_start_d = 1'b1;
          state_d     = ST_COR;
        end
      end
      ST_COR: begin
        if (cor_done) begin
          st_d        = cor_s;
          ct_d        = cor_c;
          mul_a_d     = MUL_W'(r30_q);
          mul_b_d     = MUL_W'(RAD2DEG_Q24);
          mul_start_d = 1'b1;
          state_d     = ST_DEG;
        end
      end
      ST_DEG: begin
        if (mul_done) begin
          gang_d = neg_q ? -$signed(gdeg) : $signed(gdeg);
          if ((kind_q == KIND_LOOP) && (axis_q <= AXIS_Z)) begin
            div_n_d     = {32'd0, (diff_q[31] ? 32'(-diff_q) : 32'(diff_q))};
            div_d_d     = D_DIFF;
            div_start_d = 1'b1;
            state_d     = ST_RED2;
          end else begin
            mul_a_d     = MUL_W'(amp_q);
            mul_b_d     = MUL_W'(m4_trig);
            mul_start_d = 1'b1;
            state_d     = ST_M4;
          end
        end
      end
      ST_RED2: begin
        if (div_done) begin
          cor_z_d     = r30_diff;
          cor_neg_d   = diff_q[31];
          cor_start_d = 1'b1;
          state_d     = ST_COR2;
        end
      end
      ST_COR2: begin
        if (cor_done) begin
          sp_d        = cor_s;
          cp_d        = cor_c;
          mul_a_d     = MUL_W'(amp_q);
          mul_b_d     = MUL_W'(m4_trig);
          mul_start_d = 1'b1;
          state_d     = ST_M4;
        end
      end
      ST_M4: begin
        if (mul_done) begin
          term_d  = '0;
          state_d = ST_ACC;
          if (kind_q == KIND_DRIFT) begin
            term_d = 66'(drift_rnd) + 66'(t_rnd);
          end else if (axis_q <= AXIS_Z) begin
            case (kind_q)
              KIND_CIRC, KIND_SINE, KIND_RECT: term_d = 66'(t_rnd);
              KIND_CUBIC: begin
                mul_a_d     = MUL_W'(t_rnd);
                mul_b_d     = MUL_W'(INV_SQRT2_Q30);
                mul_start_d = 1'b1;
                state_d     = ST_M5;
              end
              KIND_LOOP: begin
                mul_a_d     = MUL_W'(t_rnd);
                mul_b_d     = MUL_W'(use_cos ? sp_q : cp_q);
                mul_start_d = 1'b1;
                state_d     = ST_M5;
              end
              KIND_SAW: begin
                if (axis_q == AXIS_Y) begin
                  mul_a_d     = MUL_W'(amp_q);
                  mul_b_d     = MUL_W'(gang_q);
                  mul_start_d = 1'b1;
                  state_d     = ST_SAWMUL;
                end
              end
              default: term_d = '0;
            endcase
          end
        end
      end
      ST_M5: begin
        if (mul_done) begin
          term_d  = (kind_q == KIND_LOOP) ? 66'(t_rnd) : cubic_term;
          state_d = ST_ACC;
        end
      end
      ST_SAWMUL: begin
        // mul done: launch |A*gang| / 360; the divider pass ends back here
        if (mul_done) begin
          sawneg_d    = mul_p[2*MUL_W-1];
          div_n_d     = abs_p;
          div_d_d     = D_DEG;
          div_start_d = 1'b1;
        end else if (div_done) begin
          term_d  = sawneg_q ? -66'(div_q) : 66'(div_q);
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last_q || out_free) begin
          if (sum_w[66:31] != {36{sum_w[66]}}) begin
            sum_d = sum_w[66] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            sat_d = 1'b1;
          end else begin
            sum_d = sum_w[31:0];
          end
          if (last_q) begin
            pos_d    = (sum_w[66:31] != {36{sum_w[66]}}) ?
                       (sum_w[66] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum_w[31:0];
            osat_d   = sat_q || (sum_w[66:31] != {36{sum_w[66]}});
            ovalid_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      ovalid_q    <= 1'b0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      cor_start_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      ovalid_q    <= ovalid_d;
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      cor_start_q <= cor_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q    <= axis_d;
    kind_q    <= kind_d;
    odd_q     <= odd_d;
    last_q    <= last_d;
    amp_q     <= amp_d;
    speed_q   <= speed_d;
    ang_q     <= ang_d;
    diff_q    <= diff_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    sawneg_q  <= sawneg_d;
    r30_q     <= r30_d;
    st_q      <= st_d;
    ct_q      <= ct_d;
    sp_q      <= sp_d;
    cp_q      <= cp_d;
    gang_q    <= gang_d;
    term_q    <= term_d;
    pos_q     <= pos_d;
    osat_q    <= osat_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    div_n_q   <= div_n_d;
    div_d_q   <= div_d_d;
    cor_z_q   <= cor_z_d;
    cor_neg_q <= cor_neg_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = pos_q;
  assign m_axis_tuser_o  = osat_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_no_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(mul_start_q || div_start_q || cor_start_q))
    else $error("unit launched while idle");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && last_q && ovalid_q && !m_axis_tready_i)
      |=> (state_q == ST_ACC)) else $error("result overwrote a pending transaction");

  a_start_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |=> !mul_start_q) else $error("multiplier start held");

endmodule
